FILE: hw/rtl/triangle_unit_normal_defines.svh
// ---------------------------------------------------------------------------
// Triangle unit normal: assertion macros
// Shared macros for the concurrent checks on the triangle normal unit.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// The condition must never hold outside reset.
`define TUN_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define TUN_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tun_pkg.sv
// ---------------------------------------------------------------------------
// Triangle unit normal package
// Widths, stage counts and the side-band type shared by the pipeline.
// ---------------------------------------------------------------------------
package tun_pkg;

  localparam int CoordW = 32;
  localparam int EdgeW  = 33;
  localparam int ProdW  = 66;
  localparam int CrossW = 67;
  localparam int MagW   = 65;
  localparam int PosW   = 7;
  localparam int ChunkN = 9;
  localparam int AlignW = 31;
  localparam int SqW    = 62;
  localparam int SumW   = 64;
  localparam int RootW  = 32;
  localparam int RemW   = 34;
  localparam int QuoW   = 16;
  localparam int NormW  = 16;
  localparam int NumW   = AlignW + QuoW;

  localparam int CrossStages = 4;
  localparam int NormStages  = 5;
  localparam int DivStages   = QuoW + 2;
  localparam int Latency     = CrossStages + NormStages + RootW + DivStages;

  localparam logic [QuoW-1:0] SatMax = 16'd32767;

  // Per-item data that rides beside the square root.
  typedef struct packed {
    logic [2:0]              neg;
    logic                    degen;
    logic [2:0][AlignW-1:0]  a;
  } side_t;

endpackage

FILE: hw/rtl/tun_cross.sv
// ---------------------------------------------------------------------------
// Triangle unit normal: cross product
// Edge vectors, partial products and the exact cross product in four stages.
// ---------------------------------------------------------------------------
module tun_cross (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [2:0][tun_pkg::CoordW-1:0]      v0,
  input  logic [2:0][tun_pkg::CoordW-1:0]      v1,
  input  logic [2:0][tun_pkg::CoordW-1:0]      v2,
  output logic                                 out_valid,
  output logic [2:0][tun_pkg::MagW-1:0]        mag,
  output logic [2:0]                           neg
);

  logic [tun_pkg::CrossStages-1:0]      vld;
  logic signed [tun_pkg::EdgeW-1:0]     e1 [3];
  logic signed [tun_pkg::EdgeW-1:0]     e2 [3];
  logic signed [tun_pkg::ProdW-1:0]     p [3];
  logic signed [tun_pkg::ProdW-1:0]     q [3];
  logic signed [tun_pkg::CrossW-1:0]    c [3];
  logic signed [tun_pkg::CrossW-1:0]    cabs [3];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[tun_pkg::CrossStages-2:0], in_valid};
    end
  end

  // Magnitude of each cross component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = c[i][tun_pkg::CrossW-1] ? -c[i] : c[i];
    end
  end

  // Edges, products, differences and sign split.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1[i] <= $signed({v1[i][tun_pkg::CoordW-1], v1[i]})
             - $signed({v0[i][tun_pkg::CoordW-1], v0[i]});
      e2[i] <= $signed({v2[i][tun_pkg::CoordW-1], v2[i]})
             - $signed({v1[i][tun_pkg::CoordW-1], v1[i]});
    end
    p[0] <= e1[1] * e2[2];
    q[0] <= e1[2] * e2[1];
    p[1] <= e1[2] * e2[0];
    q[1] <= e1[0] * e2[2];
    p[2] <= e1[0] * e2[1];
    q[2] <= e1[1] * e2[0];
    for (int i = 0; i < 3; i++) begin
      c[i]   <= $signed({p[i][tun_pkg::ProdW-1], p[i]})
              - $signed({q[i][tun_pkg::ProdW-1], q[i]});
      neg[i] <= c[i][tun_pkg::CrossW-1];
      mag[i] <= cabs[i][tun_pkg::MagW-1:0];
    end
  end

  assign out_valid = vld[tun_pkg::CrossStages-1];

endmodule

FILE: hw/rtl/tun_norm.sv
// ---------------------------------------------------------------------------
// Triangle unit normal: alignment and squared length
// Finds the top set bit, aligns the magnitudes to bit 30 and sums squares.
// ---------------------------------------------------------------------------
module tun_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [2:0][tun_pkg::MagW-1:0]     mag,
  input  logic [2:0]                        neg,
  output logic                              out_valid,
  output logic [tun_pkg::SumW-1:0]          sum,
  output tun_pkg::side_t                    side
);

  logic [tun_pkg::NormStages-1:0]           vld;
  logic [8*tun_pkg::ChunkN-1:0]             orw;
  logic [tun_pkg::ChunkN-1:0]               nz_c;
  logic [tun_pkg::ChunkN-1:0][2:0]          top_c;
  logic [tun_pkg::PosW-1:0]                 pos_c;
  logic [tun_pkg::MagW+29:0]                wide [3];
  logic [tun_pkg::MagW+29:0]                shf [3];
  logic [2:0][tun_pkg::MagW-1:0]            m1;
  logic [2:0][tun_pkg::MagW-1:0]            m2;
  logic [2:0]                               ng1, ng2, ng3, ng4;
  logic [tun_pkg::ChunkN-1:0]               nz1;
  logic [tun_pkg::ChunkN-1:0][2:0]          top1;
  logic [tun_pkg::PosW-1:0]                 pos2;
  logic                                     dg2, dg3, dg4;
  logic [2:0][tun_pkg::AlignW-1:0]          a3, a4;
  logic [tun_pkg::SqW-1:0]                  sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[tun_pkg::NormStages-2:0], in_valid};
    end
  end

  // Top bit inside each byte of the combined magnitude word.
  always_comb begin
    orw = {{(8*tun_pkg::ChunkN-tun_pkg::MagW){1'b0}}, mag[0] | mag[1] | mag[2]};
    for (int k = 0; k < tun_pkg::ChunkN; k++) begin
      nz_c[k]  = |orw[8*k +: 8];
      top_c[k] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orw[8*k+b]) top_c[k] = 3'(b);
      end
    end
  end

  // Highest nonzero byte gives the leading bit position.
  always_comb begin
    pos_c = '0;
    for (int k = 0; k < tun_pkg::ChunkN; k++) begin
      if (nz1[k]) pos_c = {4'(k), top1[k]};
    end
  end

  // Shift so that the leading bit lands on bit 30.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {m2[i], 30'd0};
      shf[i]  = wide[i] >> pos2;
    end
  end

  always_ff @(posedge clk) begin
    m1   <= mag;
    ng1  <= neg;
    nz1  <= nz_c;
    top1 <= top_c;

    m2   <= m1;
    ng2  <= ng1;
    pos2 <= pos_c;
    dg2  <= ~|nz1;

    for (int i = 0; i < 3; i++) begin
      a3[i] <= shf[i][tun_pkg::AlignW-1:0];
    end
    ng3 <= ng2;
    dg3 <= dg2;

    for (int i = 0; i < 3; i++) begin
      sq[i] <= a3[i] * a3[i];
    end
    a4  <= a3;
    ng4 <= ng3;
    dg4 <= dg3;

    sum        <= tun_pkg::SumW'(sq[0]) + tun_pkg::SumW'(sq[1]) + tun_pkg::SumW'(sq[2]);
    side.a     <= a4;
    side.neg   <= ng4;
    side.degen <= dg4;
  end

  assign out_valid = vld[tun_pkg::NormStages-1];

endmodule

FILE: hw/rtl/tun_sqrt.sv
// ---------------------------------------------------------------------------
// Triangle unit normal: integer square root
// One root bit per stage, 32 stages, floor of the square root of a 64-bit word.
// ---------------------------------------------------------------------------
module tun_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [tun_pkg::SumW-1:0]      in_sum,
  input  tun_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [tun_pkg::RootW-1:0]     root_out,
  output tun_pkg::side_t                out_side
);

  logic [tun_pkg::RootW:0]           vld;
  logic [tun_pkg::SumW-1:0]          rad  [tun_pkg::RootW+1];
  logic [tun_pkg::RemW-1:0]          rem  [tun_pkg::RootW+1];
  logic [tun_pkg::RootW-1:0]         root [tun_pkg::RootW+1];
  tun_pkg::side_t                    sd   [tun_pkg::RootW+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_sum;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sd[0]   = in_side;

  for (genvar k = 0; k < tun_pkg::RootW; k++) begin : g_stage
    logic [tun_pkg::RemW+1:0]   t;
    logic [tun_pkg::RemW+1:0]   trial;
    logic [tun_pkg::RemW-1:0]   rem_next;
    logic [tun_pkg::RootW-1:0]  root_next;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      t     = {rem[k], rad[k][tun_pkg::SumW-1 -: 2]};
      trial = {2'b00, root[k], 2'b01};
      if (t >= trial) begin
        rem_next  = tun_pkg::RemW'(t - trial);
        root_next = {root[k][tun_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_next  = t[tun_pkg::RemW-1:0];
        root_next = {root[k][tun_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rad[k+1]  <= rad[k] << 2;
      rem[k+1]  <= rem_next;
      root[k+1] <= root_next;
      sd[k+1]   <= sd[k];
    end
  end

  assign out_valid = vld[tun_pkg::RootW];
  assign root_out  = root[tun_pkg::RootW];
  assign out_side  = sd[tun_pkg::RootW];

endmodule

FILE: hw/rtl/tun_div.sv
// ---------------------------------------------------------------------------
// Triangle unit normal: rounded division and output stage
// Three restoring dividers, one quotient bit per stage, then saturation.
// ---------------------------------------------------------------------------
module tun_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [tun_pkg::RootW-1:0]        len,
  input  tun_pkg::side_t                   side,
  output logic                             out_valid,
  output logic [2:0][tun_pkg::NormW-1:0]   norm,
  output logic                             degen
);

  logic [tun_pkg::QuoW+1:0]                  vld;
  logic [tun_pkg::NumW-1:0]                  num_c [3];
  logic [2:0][tun_pkg::RootW-1:0]            rem  [tun_pkg::QuoW+1];
  logic [2:0][tun_pkg::QuoW-1:0]             bits [tun_pkg::QuoW+1];
  logic [2:0][tun_pkg::QuoW-1:0]             quo  [tun_pkg::QuoW+1];
  logic [tun_pkg::RootW-1:0]                 dv   [tun_pkg::QuoW+1];
  logic [2:0]                                ng   [tun_pkg::QuoW+1];
  logic [tun_pkg::QuoW:0]                    dg;
  logic [2:0][tun_pkg::QuoW-1:0]             sat_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[tun_pkg::QuoW:0], in_valid};
    end
  end

  // Numerator is the aligned magnitude scaled by 2^15 plus half the length.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = tun_pkg::NumW'({side.a[i], 15'd0}) + tun_pkg::NumW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i]  <= tun_pkg::RootW'(num_c[i][tun_pkg::NumW-1:tun_pkg::QuoW]);
      bits[0][i] <= num_c[i][tun_pkg::QuoW-1:0];
      quo[0][i]  <= '0;
    end
    dv[0] <= len;
    ng[0] <= side.neg;
    dg[0] <= side.degen;
  end

  for (genvar k = 0; k < tun_pkg::QuoW; k++) begin : g_stage
    logic [2:0][tun_pkg::RootW-1:0]  rem_next;
    logic [2:0]                      qbit;
    logic [tun_pkg::RootW:0]         t [3];
    logic [tun_pkg::RootW:0]         diff [3];

    // Shift in one numerator bit and subtract the length where it fits.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {rem[k][i], bits[k][i][tun_pkg::QuoW-1]};
        diff[i] = t[i] - {1'b0, dv[k]};
        qbit[i] = (t[i] >= {1'b0, dv[k]});
        rem_next[i] = qbit[i] ? diff[i][tun_pkg::RootW-1:0] : t[i][tun_pkg::RootW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        rem[k+1][i]  <= rem_next[i];
        bits[k+1][i] <= bits[k][i] << 1;
        quo[k+1][i]  <= {quo[k][i][tun_pkg::QuoW-2:0], qbit[i]};
      end
      dv[k+1] <= dv[k];
      ng[k+1] <= ng[k];
      dg[k+1] <= dg[k];
    end
  end

  // Saturate the quotient to the largest Q1.15 magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_c[i] = (quo[tun_pkg::QuoW][i] > tun_pkg::SatMax) ? tun_pkg::SatMax
                                                            : quo[tun_pkg::QuoW][i];
    end
  end

  // Output word: sign applied, forced to zero for a degenerate triangle.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dg[tun_pkg::QuoW]) begin
        norm[i] <= '0;
      end else if (ng[tun_pkg::QuoW][i]) begin
        norm[i] <= -sat_c[i];
      end else begin
        norm[i] <= sat_c[i];
      end
    end
    degen <= dg[tun_pkg::QuoW];
  end

  assign out_valid = vld[tun_pkg::QuoW+1];

endmodule

FILE: hw/rtl/triangle_unit_normal.sv
// ---------------------------------------------------------------------------
// Triangle unit normal
// Unit face normal of a triangle given as three Q16.16 vertices.
// ---------------------------------------------------------------------------
// A triangle word is taken on every clock edge where start is high; busy is
// always low, so one word can enter per cycle with no gaps. Each word passes
// 59 register stages: 4 for the exact cross product, 5 for leading-bit
// alignment and the squared length, 32 for the bit-per-stage square root and
// 18 for the three bit-per-stage dividers with rounding, saturation and the
// output register. Its result word is shown for one cycle with done high,
// driven from that output register. Results come out in input order and
// cannot be held off. A zero cross product gives a zero normal with
// degenerate high.
module triangle_unit_normal (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  first_x,
  input  logic signed [31:0]  first_y,
  input  logic signed [31:0]  first_z,
  input  logic signed [31:0]  second_x,
  input  logic signed [31:0]  second_y,
  input  logic signed [31:0]  second_z,
  input  logic signed [31:0]  third_x,
  input  logic signed [31:0]  third_y,
  input  logic signed [31:0]  third_z,
  output logic                done,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic                degenerate
);

  logic                                  acc;
  logic [2:0][tun_pkg::CoordW-1:0]       v0, v1, v2;
  logic                                  cr_valid;
  logic [2:0][tun_pkg::MagW-1:0]         cr_mag;
  logic [2:0]                            cr_neg;
  logic                                  nm_valid;
  logic [tun_pkg::SumW-1:0]              nm_sum;
  tun_pkg::side_t                        nm_side;
  logic                                  sq_valid;
  logic [tun_pkg::RootW-1:0]             sq_root;
  tun_pkg::side_t                        sq_side;
  logic [2:0][tun_pkg::NormW-1:0]        norm;

  // The pipeline never stalls.
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  assign v0 = {first_z, first_y, first_x};
  assign v1 = {second_z, second_y, second_x};
  assign v2 = {third_z, third_y, third_x};

  tun_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc),
    .v0        (v0),
    .v1        (v1),
    .v2        (v2),
    .out_valid (cr_valid),
    .mag       (cr_mag),
    .neg       (cr_neg)
  );

  tun_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cr_valid),
    .mag       (cr_mag),
    .neg       (cr_neg),
    .out_valid (nm_valid),
    .sum       (nm_sum),
    .side      (nm_side)
  );

  tun_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nm_valid),
    .in_sum    (nm_sum),
    .in_side   (nm_side),
    .out_valid (sq_valid),
    .root_out  (sq_root),
    .out_side  (sq_side)
  );

  tun_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .len       (sq_root),
    .side      (sq_side),
    .out_valid (done),
    .norm      (norm),
    .degen     (degenerate)
  );

  assign normal_x = norm[0];
  assign normal_y = norm[1];
  assign normal_z = norm[2];

endmodule

FILE: hw/rtl/tun_checker.sv
// ---------------------------------------------------------------------------
// Triangle unit normal checker
// Port-level checks on latency, saturation and the degenerate case.
// ---------------------------------------------------------------------------
`include "triangle_unit_normal_defines.svh"

module tun_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic               degenerate
);

  // Every result word traces back to a word taken a fixed latency earlier.
  `TUN_ASSERT_IMPLY(a_latency, clk, rst, done, $past(start, tun_pkg::Latency), "result without a matching input word")

  // A degenerate triangle gives the zero vector.
  `TUN_ASSERT_IMPLY(a_degen_zero, clk, rst, done && degenerate, normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0, "degenerate result is not zero")

  // A proper triangle never gives the zero vector.
  `TUN_ASSERT_IMPLY(a_nonzero, clk, rst, done && !degenerate, normal_x != 16'sd0 || normal_y != 16'sd0 || normal_z != 16'sd0, "normal of a proper triangle is zero")

  // Saturation keeps every component off the most negative code.
  `TUN_ASSERT_NEVER(a_no_min, clk, rst, done && (normal_x == 16'h8000 || normal_y == 16'h8000 || normal_z == 16'h8000), "component reached -32768")

  // The pipeline can take a word in every cycle: busy never goes high.
  `TUN_ASSERT_NEVER(a_never_busy, clk, rst, busy, "busy went high")

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .normal_x   (normal_x),
  .normal_y   (normal_y),
  .normal_z   (normal_z),
  .degenerate (degenerate)
);

FILE: verif/triangle_unit_normal_test.sv
// ---------------------------------------------------------------------------
// Triangle unit normal testbench
// Drives triangle words through the normal unit, predicts each unit normal
// with a local fixed-point model and compares every result word in order.
// ---------------------------------------------------------------------------
module triangle_unit_normal_test;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
  logic signed [31:0] third_x = '0, third_y = '0, third_z = '0;
  logic done;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic degenerate;

  normal_t expected_normals[$];
  int      error_count = 0;
  bit      idle_enable = 1'b1;

  triangle_unit_normal uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .third_x(third_x), .third_y(third_y), .third_z(third_z),
    .done(done), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  // Integer square root, floor, of a 64-bit value.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Unit normal of one triangle, from the exact cross product.
  function automatic normal_t unit_normal(logic signed [31:0] v[9]);
    logic signed [32:0]  e1[3], e2[3];
    logic signed [66:0]  cr[3];
    logic [66:0]         mag[3];
    logic [63:0]         al[3];
    logic [63:0]         sq_sum, len, q;
    logic [15:0]         outv[3];
    int                  top, sh;
    normal_t             r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 33'(v[3+i]) - 33'(v[i]);
      e2[i] = 33'(v[6+i]) - 33'(v[3+i]);
    end
    cr[0] = 67'(e1[1]) * 67'(e2[2]) - 67'(e1[2]) * 67'(e2[1]);
    cr[1] = 67'(e1[2]) * 67'(e2[0]) - 67'(e1[0]) * 67'(e2[2]);
    cr[2] = 67'(e1[0]) * 67'(e2[1]) - 67'(e1[1]) * 67'(e2[0]);
    top = -1;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int b = 0; b < 67; b++) if (mag[i][b] && b > top) top = b;
    end
    r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1'b1;
    if (top < 0) return r;
    sq_sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (top > 30) begin
        sh = top - 30;
        al[i] = 64'(mag[i] >> sh);
      end else begin
        al[i] = 64'(mag[i]) << (30 - top);
      end
      sq_sum = sq_sum + al[i] * al[i];
    end
    len = floor_sqrt(sq_sum);
    for (int i = 0; i < 3; i++) begin
      q = ((al[i] << 15) + (len >> 1)) / len;
      if (q > 64'd32767) q = 64'd32767;
      outv[i] = cr[i] < 0 ? 16'(-q) : 16'(q);
    end
    r.nx = outv[0]; r.ny = outv[1]; r.nz = outv[2]; r.degen = 1'b0;
    return r;
  endfunction

  // Send one triangle word and queue its expected normal.
  task automatic send_triangle(logic signed [31:0] v[9]);
    if (idle_enable) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    {first_x, first_y, first_z} <= {v[0], v[1], v[2]};
    {second_x, second_y, second_z} <= {v[3], v[4], v[5]};
    {third_x, third_y, third_z} <= {v[6], v[7], v[8]};
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_normals.push_back(unit_normal(v));
  endtask

  task automatic send_values(logic signed [31:0] a0, a1, a2, b0, b1, b2,
                             c0, c1, c2);
    logic signed [31:0] v[9];
    v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    send_triangle(v);
  endtask

  // Random coordinate: full range, small range, an extreme or a random value shifted right.
  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(3))
      0: return 32'($urandom);
      1: return 32'(int'($urandom_range(131072)) - 65536);
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  // Stop sending and wait until every expected result word has come.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
  endtask

  // Directed: degenerate triangles, axis-aligned normals and extremes.
  task automatic test_directed();
    send_values(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_values(5, 5, 5, 5, 5, 5, 9, 9, 9);
    send_values(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
    send_values(0, 0, 0, 0, 65536, 0, 65536, 0, 0);
    send_values(0, 0, 0, 0, 65536, 0, 0, 0, 65536);
    send_values(0, 0, 0, 0, 0, 65536, 65536, 0, 0);
    send_values(32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_values(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_values(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_values(0, 0, 0, 32'sh7fffffff, 1, 0, 32'sh80000000, 0, 1);
    send_values(0, 0, 0, 65536, 65536, 65536, 1, 0, 0);
    send_values(-1, -1, -1, 1, 2, 3, 3, 5, 7);
    send_values(0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0);
    send_values(-65536, 0, 0, 0, 65536, 0, 0, 0, 32'sh7fffffff);
  endtask

  // Random triangles, some made collinear; a stretch runs with no sender idling.
  task automatic test_random(int count);
    logic signed [31:0] v[9];
    for (int n = 0; n < count; n++) begin
      idle_enable = !(n >= count / 3 && n < count / 2);
      for (int i = 0; i < 9; i++) v[i] = random_coord();
      if ($urandom_range(19) == 0) begin
        v[6] = v[3] + (v[3] - v[0]);
        v[7] = v[4] + (v[4] - v[1]);
        v[8] = v[5] + (v[5] - v[2]);
      end
      send_triangle(v);
    end
    idle_enable = 1'b1;
  endtask

  // Check each result word against the oldest expected normal.
  always @(posedge clk) begin
    normal_t e;
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: result word with no expected normal", $time);
        error_count++;
      end else begin
        e = expected_normals.pop_front();
        if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
            degenerate !== e.degen) begin
          $display("%0t: expected (%0d %0d %0d deg %0b) actual (%0d %0d %0d deg %0b)",
                   $time, e.nx, e.ny, e.nz, e.degen,
                   normal_x, normal_y, normal_z, degenerate);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("triangle_unit_normal_test: done, errors");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(640);
    wait_drained();
    repeat (tun_pkg::Latency + 10) @(posedge clk);
    if (error_count == 0 && expected_normals.size() == 0) begin
      $display("triangle_unit_normal_test: done, clean");
    end else begin
      $display("triangle_unit_normal_test: done, errors");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tun_pkg.sv
hw/rtl/tun_cross.sv
hw/rtl/tun_norm.sv
hw/rtl/tun_sqrt.sv
hw/rtl/tun_div.sv
hw/rtl/triangle_unit_normal.sv
hw/rtl/tun_checker.sv
verif/triangle_unit_normal_test.sv
